### src/lobm_pkg.sv
// -----------------------------------------------------------------------------
// Limit order book matcher package
// Shared payload types, codes and controller types for the order book.
// -----------------------------------------------------------------------------
package lobm_pkg;

   localparam int MAX_RESULTS = 64;
   localparam int NFILL_W     = $clog2(MAX_RESULTS + 1);
   localparam int FILL_AW     = $clog2(MAX_RESULTS);

   localparam logic [1:0] OP_PLACE  = 2'd0;
   localparam logic [1:0] OP_MARKET = 2'd1;
   localparam logic [1:0] OP_CANCEL = 2'd2;

   localparam logic [1:0] KIND_ACK      = 2'd0;
   localparam logic [1:0] KIND_FILL     = 2'd1;
   localparam logic [1:0] KIND_MKT_NONE = 2'd2;
   localparam logic [1:0] KIND_REJECT   = 2'd3;

   localparam logic [1:0] ERR_NONE      = 2'd0;
   localparam logic [1:0] ERR_NOT_FOUND = 2'd1;
   localparam logic [1:0] ERR_DUPLICATE = 2'd2;
   localparam logic [1:0] ERR_FULL      = 2'd3;

   typedef struct packed {
      logic [1:0]  operation;
      logic [31:0] order_id;
      logic        side;
      logic [31:0] price;
      logic [31:0] size;
   } req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [1:0]  error_code;
      logic [31:0] resting_order_id;
      logic        resting_side;
      logic [31:0] fill_size;
      logic [31:0] fill_price;
      logic [31:0] unfilled_size;
      logic        last;
      logic [47:0] ask_volume;
      logic [47:0] bid_volume;
   } rsp_type;

   typedef struct packed {
      logic [31:0] id;
      logic        side;
      logic [31:0] fill;
      logic [31:0] price;
      logic [31:0] unfilled;
   } fill_rec_type;

   typedef struct packed {
      logic accept;
      logic scan_start;
      logic scan_step;
      logic clear_step;
      logic decide;
      logic load_single;
      logic fill_read;
      logic load_fill;
   } cmd_type;

   typedef struct packed {
      logic scan_last;
      logic out_free;
      logic mkt_rescan;
      logic emit_fills;
      logic fill_last;
   } sts_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_SCAN_END,
      ST_DECIDE,
      ST_SINGLE,
      ST_FILL_RD,
      ST_FILL_OUT
   } state_type;

endpackage

### src/lobm_ram.sv
// -----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// -----------------------------------------------------------------------------
module lobm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### src/lobm_datapath.sv
// -----------------------------------------------------------------------------
// Limit order book datapath
// Order table, table scan, fill buffer, running volumes and result register.
// -----------------------------------------------------------------------------
module lobm_datapath import lobm_pkg::*; #(
   parameter int MAX_ORDERS = 64,
   parameter int PRICE_BITS = 32,
   parameter int SIZE_BITS  = 32
) (
   input  logic    clock,
   input  logic    reset,
   input  cmd_type cmd,
   output sts_type sts,
   input  req_type req_data,
   input  logic    rsp_stall,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   localparam int AW = $clog2(MAX_ORDERS);

   typedef struct packed {
      logic                  valid;
      logic [31:0]           id;
      logic                  side;
      logic [PRICE_BITS-1:0] price;
      logic [SIZE_BITS-1:0]  size;
      logic [31:0]           arrival;
   } slot_type;

   localparam int SLOT_W = $bits(slot_type);

   logic [1:0]            op_ff;
   logic [31:0]           id_ff;
   logic                  side_ff;
   logic [PRICE_BITS-1:0] price_ff;
   logic [SIZE_BITS-1:0]  rem_ff;
   logic [31:0]           cnt_ff;
   logic [47:0]           ask_ff;
   logic [47:0]           bid_ff;
   logic [NFILL_W-1:0]    nfill_ff;
   logic [NFILL_W-1:0]    emit_ff;
   logic [AW-1:0]         idx_ff;
   logic [AW-1:0]         rd_idx_ff;
   logic                  rd_vld_ff;

   logic                  found_ff;
   logic [AW-1:0]         found_idx_ff;
   logic                  found_side_ff;
   logic [SIZE_BITS-1:0]  found_size_ff;
   logic                  free_ff;
   logic [AW-1:0]         free_idx_ff;
   logic                  best_ff;
   logic [AW-1:0]         best_idx_ff;
   logic [31:0]           best_id_ff;
   logic [PRICE_BITS-1:0] best_price_ff;
   logic [SIZE_BITS-1:0]  best_size_ff;
   logic [31:0]           best_arr_ff;
   logic [31:0]           best_age_ff;

   logic [1:0]            res_kind_ff;
   logic [1:0]            res_err_ff;
   logic                  rsp_valid_ff;
   rsp_type               rsp_ff;

   logic                  slot_wr_en;
   logic [AW-1:0]         slot_wr_addr;
   slot_type              slot_wr;
   logic [SLOT_W-1:0]     slot_rd_data;
   slot_type              rd_rec;
   logic                  fill_wr_en;
   fill_rec_type          fill_wr;
   logic [$bits(fill_rec_type)-1:0] fill_rd_data;
   fill_rec_type          fill_rd;

   logic                  opp;
   logic                  place_ok;
   logic                  dec_fill;
   logic [SIZE_BITS-1:0]  fill_amt;
   logic [SIZE_BITS-1:0]  new_size;
   logic [SIZE_BITS-1:0]  rem_next;
   logic [31:0]           rd_age;
   logic                  rd_better;
   logic                  vol_en;
   logic                  vol_sub;
   logic                  vol_side;
   logic [47:0]           vol_amt;
   logic [47:0]           vol_cur;
   logic [47:0]           vol_new;
   logic                  out_free;

   assign opp      = ~side_ff;
   assign place_ok = !found_ff && (rem_ff != '0) && free_ff;
   assign dec_fill = (op_ff == OP_MARKET) && best_ff && (rem_ff != '0);
   assign fill_amt = (rem_ff < best_size_ff) ? rem_ff : best_size_ff;
   assign new_size = best_size_ff - fill_amt;
   assign rem_next = rem_ff - fill_amt;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   assign rd_rec    = slot_type'(slot_rd_data);
   assign rd_age    = cnt_ff - rd_rec.arrival;
   assign rd_better = !best_ff ||
                      ((rd_rec.price != best_price_ff) ?
                       (opp ? (rd_rec.price > best_price_ff) : (rd_rec.price < best_price_ff)) :
                       (rd_age > best_age_ff));

   always_comb begin
      slot_wr_en   = 1'b0;
      slot_wr_addr = idx_ff;
      slot_wr      = '0;
      if (cmd.clear_step) begin
         slot_wr_en = 1'b1;
      end else if (cmd.decide) begin
         unique case (op_ff)
            OP_PLACE: begin
               slot_wr_en   = place_ok;
               slot_wr_addr = free_idx_ff;
               slot_wr      = '{valid: 1'b1, id: id_ff, side: side_ff, price: price_ff,
                                size: rem_ff, arrival: cnt_ff};
            end
            OP_CANCEL: begin
               slot_wr_en   = found_ff;
               slot_wr_addr = found_idx_ff;
            end
            OP_MARKET: begin
               slot_wr_en   = dec_fill;
               slot_wr_addr = best_idx_ff;
               slot_wr      = '{valid: (new_size != '0), id: best_id_ff, side: opp,
                                price: best_price_ff, size: new_size, arrival: best_arr_ff};
            end
            default: begin
               slot_wr_en = 1'b0;
            end
         endcase
      end
   end

   lobm_ram #(.WIDTH(SLOT_W), .DEPTH(MAX_ORDERS)) u_slots (
      .clock   (clock),
      .wr_en   (slot_wr_en),
      .wr_addr (slot_wr_addr),
      .wr_data (SLOT_W'(slot_wr)),
      .rd_en   (cmd.scan_step),
      .rd_addr (idx_ff),
      .rd_data (slot_rd_data)
   );

   assign fill_wr_en = cmd.decide && dec_fill;
   assign fill_wr    = '{id: best_id_ff, side: opp, fill: 32'(fill_amt),
                         price: 32'(best_price_ff), unfilled: 32'(rem_next)};

   lobm_ram #(.WIDTH($bits(fill_rec_type)), .DEPTH(MAX_RESULTS)) u_fills (
      .clock   (clock),
      .wr_en   (fill_wr_en),
      .wr_addr (nfill_ff[FILL_AW-1:0]),
      .wr_data (fill_wr),
      .rd_en   (cmd.fill_read),
      .rd_addr (emit_ff[FILL_AW-1:0]),
      .rd_data (fill_rd_data)
   );

   assign fill_rd = fill_rec_type'(fill_rd_data);

   always_comb begin
      vol_en   = 1'b0;
      vol_sub  = 1'b0;
      vol_side = side_ff;
      vol_amt  = 48'(rem_ff);
      if (cmd.decide) begin
         unique case (op_ff)
            OP_PLACE: begin
               vol_en = place_ok;
            end
            OP_CANCEL: begin
               vol_en   = found_ff;
               vol_sub  = 1'b1;
               vol_side = found_side_ff;
               vol_amt  = 48'(found_size_ff);
            end
            OP_MARKET: begin
               vol_en   = dec_fill;
               vol_sub  = 1'b1;
               vol_side = opp;
               vol_amt  = 48'(fill_amt);
            end
            default: begin
               vol_en = 1'b0;
            end
         endcase
      end
      vol_cur = vol_side ? bid_ff : ask_ff;
      vol_new = vol_sub ? (vol_cur - vol_amt) : (vol_cur + vol_amt);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         ask_ff       <= '0;
         bid_ff       <= '0;
         idx_ff       <= '0;
         rd_vld_ff    <= 1'b0;
         found_ff     <= 1'b0;
         free_ff      <= 1'b0;
         best_ff      <= 1'b0;
         nfill_ff     <= '0;
         emit_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rd_vld_ff <= cmd.scan_step;
         if (cmd.scan_start) begin
            idx_ff   <= '0;
            found_ff <= 1'b0;
            free_ff  <= 1'b0;
            best_ff  <= 1'b0;
         end else if (cmd.scan_step || cmd.clear_step) begin
            idx_ff <= idx_ff + AW'(1);
         end
         if (rd_vld_ff) begin
            if (rd_rec.valid && (rd_rec.id == id_ff) && !found_ff) begin
               found_ff <= 1'b1;
            end
            if (!rd_rec.valid && !free_ff) begin
               free_ff <= 1'b1;
            end
            if (rd_rec.valid && (rd_rec.side == opp) && rd_better) begin
               best_ff <= 1'b1;
            end
         end
         if (cmd.accept) begin
            nfill_ff <= '0;
            emit_ff  <= '0;
         end else if (fill_wr_en) begin
            nfill_ff <= nfill_ff + NFILL_W'(1);
         end else if (cmd.load_fill) begin
            emit_ff <= emit_ff + NFILL_W'(1);
         end
         if (cmd.decide && (op_ff == OP_PLACE) && place_ok) begin
            cnt_ff <= cnt_ff + 32'd1;
         end
         if (vol_en) begin
            if (vol_side) begin
               bid_ff <= vol_new;
            end else begin
               ask_ff <= vol_new;
            end
         end
         if (cmd.load_single || cmd.load_fill) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff <= idx_ff;
      if (cmd.accept) begin
         op_ff    <= req_data.operation;
         id_ff    <= req_data.order_id;
         side_ff  <= req_data.side;
         price_ff <= PRICE_BITS'(req_data.price);
         rem_ff   <= SIZE_BITS'(req_data.size);
      end else if (fill_wr_en) begin
         rem_ff <= rem_next;
      end
      if (rd_vld_ff) begin
         if (rd_rec.valid && (rd_rec.id == id_ff) && !found_ff) begin
            found_idx_ff  <= rd_idx_ff;
            found_side_ff <= rd_rec.side;
            found_size_ff <= rd_rec.size;
         end
         if (!rd_rec.valid && !free_ff) begin
            free_idx_ff <= rd_idx_ff;
         end
         if (rd_rec.valid && (rd_rec.side == opp) && rd_better) begin
            best_idx_ff   <= rd_idx_ff;
            best_id_ff    <= rd_rec.id;
            best_price_ff <= rd_rec.price;
            best_size_ff  <= rd_rec.size;
            best_arr_ff   <= rd_rec.arrival;
            best_age_ff   <= rd_age;
         end
      end
      if (cmd.decide) begin
         res_kind_ff <= KIND_ACK;
         res_err_ff  <= ERR_NONE;
         unique case (op_ff)
            OP_PLACE: begin
               if (found_ff) begin
                  res_kind_ff <= KIND_REJECT;
                  res_err_ff  <= ERR_DUPLICATE;
               end else if ((rem_ff != '0) && !free_ff) begin
                  res_kind_ff <= KIND_REJECT;
                  res_err_ff  <= ERR_FULL;
               end
            end
            OP_CANCEL: begin
               if (!found_ff) begin
                  res_kind_ff <= KIND_REJECT;
                  res_err_ff  <= ERR_NOT_FOUND;
               end
            end
            OP_MARKET: begin
               res_kind_ff <= KIND_MKT_NONE;
            end
            default: begin
               res_kind_ff <= KIND_REJECT;
            end
         endcase
      end
      if (cmd.load_single) begin
         rsp_ff <= '{kind: res_kind_ff, error_code: res_err_ff, resting_order_id: '0,
                     resting_side: 1'b0, fill_size: '0, fill_price: '0,
                     unfilled_size: (op_ff == OP_MARKET) ? 32'(rem_ff) : 32'd0,
                     last: 1'b1, ask_volume: ask_ff, bid_volume: bid_ff};
      end else if (cmd.load_fill) begin
         rsp_ff <= '{kind: KIND_FILL, error_code: ERR_NONE, resting_order_id: fill_rd.id,
                     resting_side: fill_rd.side, fill_size: fill_rd.fill,
                     fill_price: fill_rd.price, unfilled_size: fill_rd.unfilled,
                     last: sts.fill_last, ask_volume: ask_ff, bid_volume: bid_ff};
      end
   end

   assign sts.scan_last  = (idx_ff == AW'(MAX_ORDERS - 1));
   assign sts.out_free   = out_free;
   assign sts.mkt_rescan = dec_fill && (rem_next != '0) &&
                           ((nfill_ff + NFILL_W'(1)) < NFILL_W'(MAX_RESULTS));
   assign sts.emit_fills = (op_ff == OP_MARKET) && ((nfill_ff != '0) || dec_fill);
   assign sts.fill_last  = (emit_ff == (nfill_ff - NFILL_W'(1)));

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

### src/lobm_ctrl.sv
// -----------------------------------------------------------------------------
// Limit order book controller
// Sequences table clearing, scans, decisions and result delivery.
// -----------------------------------------------------------------------------
module lobm_ctrl import lobm_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  sts_type sts,
   output cmd_type cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (sts.scan_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (sts.scan_last) state_in = ST_SCAN_END;
         end
         ST_SCAN_END: begin
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            priority if (sts.mkt_rescan) state_in = ST_SCAN;
            else if (sts.emit_fills) state_in = ST_FILL_RD;
            else state_in = ST_SINGLE;
         end
         ST_SINGLE: begin
            if (sts.out_free) state_in = ST_IDLE;
         end
         ST_FILL_RD: begin
            state_in = ST_FILL_OUT;
         end
         ST_FILL_OUT: begin
            if (sts.out_free) state_in = sts.fill_last ? ST_IDLE : ST_FILL_RD;
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
         end
         ST_IDLE: begin
            req_stall      = 1'b0;
            cmd.accept     = req_valid;
            cmd.scan_start = req_valid;
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
         end
         ST_SCAN_END: begin
            cmd = '0;
         end
         ST_DECIDE: begin
            cmd.decide     = 1'b1;
            cmd.scan_start = sts.mkt_rescan;
         end
         ST_SINGLE: begin
            cmd.load_single = sts.out_free;
         end
         ST_FILL_RD: begin
            cmd.fill_read = 1'b1;
         end
         ST_FILL_OUT: begin
            cmd.load_fill = sts.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

### src/limit_order_book_matcher.sv
// -----------------------------------------------------------------------------
// Limit order book matcher
// Price-time priority order book with place, cancel and market requests.
// -----------------------------------------------------------------------------
// One request is handled at a time. Every lookup walks the order table through
// its single read port. A place, cancel or rejected request is taken, scanned
// once, and its result is loaded. A market request is taken and then scanned
// once for each resting order it fills, with one scan more when the opposite
// side runs out first; its fill results are then read back and loaded one by
// one, or one result without a fill is loaded. Stalls on the result port hold
// up result delivery. After reset the table is cleared before the first
// request is taken. A new request is taken while the previous final result
// still waits on the result port.
module limit_order_book_matcher import lobm_pkg::*; #(
   parameter int MAX_ORDERS = 64,
   parameter int PRICE_BITS = 32,
   parameter int SIZE_BITS  = 32
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   cmd_type cmd;
   sts_type sts;

   lobm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   lobm_datapath #(
      .MAX_ORDERS (MAX_ORDERS),
      .PRICE_BITS (PRICE_BITS),
      .SIZE_BITS  (SIZE_BITS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sts       (sts),
      .req_data  (req_data),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

### src/lobm_checker.sv
// -----------------------------------------------------------------------------
// Limit order book port checker
// Checks reset behaviour and result sequencing on the ports of the order book.
// -----------------------------------------------------------------------------
module lobm_checker import lobm_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_stall,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_reset_stall: assert property (@(posedge clock) reset |=> req_stall)
      else $error("request taken while the table is cleared");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   a_only_fill_open: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.kind != KIND_FILL) |-> rsp_data.last)
      else $error("non-fill result is not final");

   a_fill_no_error: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && ((rsp_data.kind == KIND_FILL) || (rsp_data.kind == KIND_ACK))
      |-> (rsp_data.error_code == ERR_NONE))
      else $error("error code on a fill or acknowledgement");

endmodule

bind limit_order_book_matcher lobm_checker u_chk (.*);
